// ----- src/rbvi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbvi_pkg: shared types and helpers for the rigid body velocity integrator
// Beat structs, configuration struct, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package rbvi_pkg;

    // APB address width: six 32-bit registers at byte offsets 0..20
    localparam int ADDR_W = 5;

    // Shared multiplier operand width (covers the 34-bit dot product)
    localparam int MW = 35;

    // Register indexes
    localparam logic [2:0] REG_MASS        = 3'd0;
    localparam logic [2:0] REG_GRAVITY_X   = 3'd1;
    localparam logic [2:0] REG_GRAVITY_Y   = 3'd2;
    localparam logic [2:0] REG_GRAVITY_Z   = 3'd3;
    localparam logic [2:0] REG_LIMIT_ALONG = 3'd4;
    localparam logic [2:0] REG_LIMIT_SIDE  = 3'd5;

    // Action codes
    localparam logic ACT_ADD_FORCE = 1'b0;
    localparam logic ACT_STEP      = 1'b1;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } ds_op_t;

    typedef struct packed {
        logic               action;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic        [15:0] time_step;
        logic               on_ground;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } out_beat_t;

    typedef struct packed {
        logic        [31:0] mass;
        logic signed [31:0] gravity_x;
        logic signed [31:0] gravity_y;
        logic signed [31:0] gravity_z;
        logic        [30:0] limit_along;
        logic        [30:0] limit_side;
    } cfg_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Divide by 2^k, truncating toward zero
    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                     input int unsigned k);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        m = m >> k;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    // Magnitude of a 32-bit signed value
    function automatic logic [32:0] mag33(input logic signed [31:0] x);
        logic signed [32:0] w;
        w = 33'(x);
        return x[31] ? 33'(-w) : 33'(w);
    endfunction

    // Give an unsigned quotient the requested sign
    function automatic logic signed [63:0] apply_sign(input logic neg, input logic [63:0] q);
        return neg ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ----- src/rigid_body_velocity_integrator_top.sv -----
// ----------------------------------------------------------------------------
// rigid_body_velocity_integrator_top: semi-implicit Euler body integrator
// add_force beat: the core moves to its output state and the result is then
// registered in the output register. step beat: the sequencer walks through the
// shared divide/root unit (up to nine divides and two roots). One beat in flight; a
// finished result waits in the output register while the next beat is taken.
// Reset (aresetn low, synchronous): state vectors zero, registers to defaults.
// ----------------------------------------------------------------------------
module rigid_body_velocity_integrator_top
    import rbvi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data
);

    localparam longint ONE_FX = longint'(1) << FRAC_BITS;
    localparam longint GY_RAW = 100 * ONE_FX;
    localparam longint LA_RAW = 1000 * ONE_FX;
    localparam longint LS_RAW = 200 * ONE_FX;
    localparam logic [31:0] MASS_RST = 32'(ONE_FX);
    localparam logic [31:0] GY_RST   = (GY_RAW > 64'sd2147483647) ? 32'h7FFF_FFFF : 32'(GY_RAW);
    localparam logic [30:0] LA_RST   = (LA_RAW > 64'sd2147483647) ? 31'h7FFF_FFFF : 31'(LA_RAW);
    localparam logic [30:0] LS_RST   = (LS_RAW > 64'sd2147483647) ? 31'h7FFF_FFFF : 31'(LS_RAW);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    logic       core_res_valid;
    logic       core_res_ready;
    out_beat_t  core_res;
    logic       m_valid_reg;
    out_beat_t  m_data_reg;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mass        <= MASS_RST;
            cfg_reg.gravity_x   <= '0;
            cfg_reg.gravity_y   <= GY_RST;
            cfg_reg.gravity_z   <= '0;
            cfg_reg.limit_along <= LA_RST;
            cfg_reg.limit_side  <= LS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MASS:        cfg_reg.mass        <= pwdata;
                REG_GRAVITY_X:   cfg_reg.gravity_x   <= pwdata;
                REG_GRAVITY_Y:   cfg_reg.gravity_y   <= pwdata;
                REG_GRAVITY_Z:   cfg_reg.gravity_z   <= pwdata;
                REG_LIMIT_ALONG: cfg_reg.limit_along <= pwdata[30:0];
                REG_LIMIT_SIDE:  cfg_reg.limit_side  <= pwdata[30:0];
                default:         cfg_reg.mass        <= cfg_reg.mass;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_MASS:        prdata = cfg_reg.mass;
            REG_GRAVITY_X:   prdata = cfg_reg.gravity_x;
            REG_GRAVITY_Y:   prdata = cfg_reg.gravity_y;
            REG_GRAVITY_Z:   prdata = cfg_reg.gravity_z;
            REG_LIMIT_ALONG: prdata = {1'b0, cfg_reg.limit_along};
            REG_LIMIT_SIDE:  prdata = {1'b0, cfg_reg.limit_side};
            default:         prdata = '0;
        endcase
    end

    rbvi_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_data),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res_beat  (core_res)
    );

    // Output register: hold the result beat until taken
    assign core_res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_res_valid && core_res_ready) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= core_res;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    // Core never takes a beat while its own result is pending
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && core_res_valid))
        else $error("input taken while core result pending");

    // An accepted beat always leaves the core busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("core still ready after accepting a beat");

    // Output valid rises only after a core hand-over
    a_out_from_core: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(core_res_valid && core_res_ready))
        else $error("output valid without core result");
`endif

endmodule

// ----- src/rbvi_divsqrt.sv -----
// ----------------------------------------------------------------------------
// rbvi_divsqrt: shared iterative divide / square-root unit
// Restoring 64/32 unsigned divide or 64-bit floor square root, one bit per
// cycle, with a done pulse after the last step.
// ----------------------------------------------------------------------------
module rbvi_divsqrt
    import rbvi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  ds_op_t      mode,
    input  logic [63:0] opa,
    input  logic [31:0] opb,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg;
    logic        done_reg;
    ds_op_t      mode_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [34:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] div_reg;

    logic [34:0] rem_d;
    logic        ge_d;
    logic [34:0] rem_s;
    logic [34:0] trial_s;
    logic        ge_s;

    // Trial subtract for one quotient or root bit
    always_comb begin
        rem_d   = {rem_reg[33:0], num_reg[63]};
        ge_d    = rem_d >= 35'(div_reg);
        rem_s   = {rem_reg[32:0], num_reg[63:62]};
        trial_s = {1'b0, quo_reg[31:0], 2'b01};
        ge_s    = rem_s >= trial_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= DS_DIV;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                // load operands
                busy_reg <= 1'b1;
                mode_reg <= mode;
                num_reg  <= opa;
                div_reg  <= opb;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= (mode == DS_DIV) ? 6'd63 : 6'd31;
            end else if (busy_reg) begin
                // advance one bit
                unique case (mode_reg)
                    DS_DIV: begin
                        rem_reg <= ge_d ? (rem_d - 35'(div_reg)) : rem_d;
                        quo_reg <= {quo_reg[62:0], ge_d};
                        num_reg <= {num_reg[62:0], 1'b0};
                    end
                    DS_SQRT: begin
                        rem_reg <= ge_s ? (rem_s - trial_s) : rem_s;
                        quo_reg <= {quo_reg[62:0], ge_s};
                        num_reg <= {num_reg[61:0], 2'b00};
                    end
                    default: begin
                        rem_reg <= rem_reg;
                    end
                endcase
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

// ----- src/rbvi_core.sv -----
// ----------------------------------------------------------------------------
// rbvi_core: sequencer and datapath of the integrator
// Holds force, velocity and position; walks one step through a shared
// multiplier and the shared divide / square-root unit, component by component.
// ----------------------------------------------------------------------------
module rbvi_core
    import rbvi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_beat,
    output logic      res_valid,
    input  logic      res_ready,
    output out_beat_t res_beat
);

    localparam int UW = FRAC_BITS + 2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC_DIV, S_ACC_MUL, S_ACC_UPD,
        S_GSQ_MUL, S_GSQ_ACC, S_GLEN, S_U_DIV,
        S_DOT_MUL, S_DOT_ACC, S_DOT_END,
        S_GND_MUL, S_GND_UPD,
        S_GRV_MUL, S_GRV_UPD,
        S_ALG_MUL, S_ALG_UPD,
        S_ALC_MUL, S_ALC_UPD,
        S_SSQ_MUL, S_SSQ_ACC, S_SLEN,
        S_SCL_MUL, S_SCL_DIV,
        S_VEL_UPD,
        S_POS_MUL, S_POS_UPD,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0]  idx_reg;
    logic [15:0] dt_reg;
    logic        ground_reg;
    logic        clamp_ph_reg;
    logic        started_reg;

    logic signed [31:0]   force_reg [3];
    logic signed [31:0]   vel_reg   [3];
    logic signed [31:0]   pos_reg   [3];
    logic signed [UW-1:0] u_reg     [3];
    logic signed [35:0]   along_reg [3];
    logic signed [35:0]   side_reg  [3];
    logic        [34:0]   mag_reg   [3];

    logic signed [31:0]   acc_reg;
    logic [31:0]          len_reg;
    logic [31:0]          lenq_reg;
    logic signed [MW-1:0] d_reg;
    logic [63:0]          sum_reg;
    logic [2:0]           sh_reg;
    logic signed [63:0]   prod_reg;

    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [2*MW-1:0] product_c;

    logic        ds_start;
    ds_op_t      ds_mode;
    logic [63:0] ds_a;
    logic [31:0] ds_b;
    logic        ds_done;
    logic [63:0] ds_q;

    logic signed [31:0] grav [3];
    logic [31:0]        mass_eff;
    logic               last;
    logic [30:0]        magq_c [3];
    logic [34:0]        mx_c;
    logic [2:0]         sh_c;
    logic signed [35:0] along_c;
    logic signed [35:0] side_c;
    logic [34:0]        mag_c;
    logic signed [MW-1:0] lim_a;
    logic [63:0]        sum_base;

    // Configuration views
    always_comb begin
        grav[0]  = cfg.gravity_x;
        grav[1]  = cfg.gravity_y;
        grav[2]  = cfg.gravity_z;
        mass_eff = (cfg.mass == '0) ? 32'd1 : cfg.mass;
        last     = (idx_reg == 2'd2);
        sum_base = (idx_reg == 2'd0) ? 64'd0 : sum_reg;
        lim_a    = $signed(MW'(cfg.limit_along));
    end

    // Sideways magnitudes: pre-shift that keeps the largest below 2^31
    always_comb begin
        mx_c = mag_reg[0];
        if (mag_reg[1] > mx_c) begin
            mx_c = mag_reg[1];
        end
        if (mag_reg[2] > mx_c) begin
            mx_c = mag_reg[2];
        end
        sh_c = 3'd7;
        for (int k = 7; k >= 0; k--) begin
            if ((mx_c >> k) < 35'd2147483648) begin
                sh_c = 3'(k);
            end
        end
        for (int k = 0; k < 3; k++) begin
            magq_c[k] = 31'(mag_reg[k] >> sh_reg);
        end
    end

    // Along and sideways parts from the current product
    always_comb begin
        along_c = 36'(trunc_shr(prod_reg, FRAC_BITS));
        side_c  = 36'(vel_reg[idx_reg]) - along_c;
        mag_c   = side_c[35] ? 35'(-side_c) : 35'(side_c);
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ACC_MUL: begin
                mul_a = MW'(acc_reg);
                mul_b = $signed(MW'(dt_reg));
            end
            S_GSQ_MUL: begin
                mul_a = $signed(MW'(mag33(grav[idx_reg])));
                mul_b = $signed(MW'(mag33(grav[idx_reg])));
            end
            S_DOT_MUL: begin
                mul_a = MW'(vel_reg[idx_reg]);
                mul_b = MW'(u_reg[idx_reg]);
            end
            S_GND_MUL, S_ALG_MUL, S_ALC_MUL: begin
                mul_a = MW'(u_reg[idx_reg]);
                mul_b = d_reg;
            end
            S_GRV_MUL: begin
                mul_a = MW'(grav[idx_reg]);
                mul_b = $signed(MW'(dt_reg));
            end
            S_SSQ_MUL: begin
                mul_a = $signed(MW'(magq_c[idx_reg]));
                mul_b = $signed(MW'(magq_c[idx_reg]));
            end
            S_SCL_MUL: begin
                mul_a = $signed(MW'(magq_c[idx_reg]));
                mul_b = $signed(MW'(cfg.limit_side));
            end
            S_POS_MUL: begin
                mul_a = MW'(vel_reg[idx_reg]);
                mul_b = $signed(MW'(dt_reg));
            end
            default: begin
                mul_a = '0;
            end
        endcase
        product_c = mul_a * mul_b;
    end

    // Divide / root operand select
    always_comb begin
        ds_mode  = DS_DIV;
        ds_a     = '0;
        ds_b     = 32'd1;
        ds_start = 1'b0;
        case (state_reg)
            S_ACC_DIV: begin
                ds_a     = 64'(mag33(force_reg[idx_reg])) << FRAC_BITS;
                ds_b     = mass_eff;
                ds_start = !started_reg;
            end
            S_GLEN, S_SLEN: begin
                ds_mode  = DS_SQRT;
                ds_a     = sum_reg;
                ds_start = !started_reg;
            end
            S_U_DIV: begin
                ds_a     = 64'(mag33(grav[idx_reg])) << FRAC_BITS;
                ds_b     = len_reg;
                ds_start = !started_reg;
            end
            S_SCL_DIV: begin
                ds_a     = $unsigned(prod_reg);
                ds_b     = lenq_reg;
                ds_start = !started_reg;
            end
            default: begin
                ds_start = 1'b0;
            end
        endcase
    end

    rbvi_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ds_start),
        .mode    (ds_mode),
        .opa     (ds_a),
        .opb     (ds_b),
        .done    (ds_done),
        .result  (ds_q)
    );

    // Sequencer and datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= $signed(product_c[63:0]);
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            started_reg  <= 1'b0;
            clamp_ph_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                force_reg[k] <= '0;
                vel_reg[k]   <= '0;
                pos_reg[k]   <= '0;
            end
        end else begin
            if (ds_start) begin
                started_reg <= 1'b1;
            end else if (ds_done) begin
                started_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        if (in_beat.action == ACT_ADD_FORCE) begin
                            force_reg[0] <= sat32(64'(force_reg[0]) + 64'(in_beat.vec_x));
                            force_reg[1] <= sat32(64'(force_reg[1]) + 64'(in_beat.vec_y));
                            force_reg[2] <= sat32(64'(force_reg[2]) + 64'(in_beat.vec_z));
                            state_reg    <= S_OUT;
                        end else begin
                            dt_reg       <= in_beat.time_step;
                            ground_reg   <= in_beat.on_ground;
                            clamp_ph_reg <= 1'b0;
                            idx_reg      <= '0;
                            state_reg    <= S_ACC_DIV;
                        end
                    end
                end
                // acceleration = force / mass
                S_ACC_DIV: begin
                    if (ds_done) begin
                        acc_reg   <= sat32(apply_sign(force_reg[idx_reg][31], ds_q));
                        state_reg <= S_ACC_MUL;
                    end
                end
                S_ACC_MUL: state_reg <= S_ACC_UPD;
                S_ACC_UPD: begin
                    vel_reg[idx_reg] <= sat32(64'(vel_reg[idx_reg]) + trunc_shr(prod_reg, 16));
                    if (last) begin
                        idx_reg   <= '0;
                        state_reg <= S_GSQ_MUL;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_ACC_DIV;
                    end
                end
                // gravity length
                S_GSQ_MUL: state_reg <= S_GSQ_ACC;
                S_GSQ_ACC: begin
                    sum_reg <= sum_base + $unsigned(prod_reg);
                    if (last) begin
                        idx_reg   <= '0;
                        state_reg <= S_GLEN;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_GSQ_MUL;
                    end
                end
                S_GLEN: begin
                    if (ds_done) begin
                        len_reg <= ds_q[31:0];
                        idx_reg <= '0;
                        if (ds_q[31:0] == '0) begin
                            for (int k = 0; k < 3; k++) begin
                                u_reg[k] <= '0;
                            end
                            state_reg <= ground_reg ? S_DOT_MUL : S_GRV_MUL;
                        end else begin
                            state_reg <= S_U_DIV;
                        end
                    end
                end
                // unit gravity
                S_U_DIV: begin
                    if (ds_done) begin
                        u_reg[idx_reg] <= UW'(apply_sign(grav[idx_reg][31], ds_q));
                        if (last) begin
                            idx_reg   <= '0;
                            state_reg <= ground_reg ? S_DOT_MUL : S_GRV_MUL;
                        end else begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                end
                // dot(v, u)
                S_DOT_MUL: state_reg <= S_DOT_ACC;
                S_DOT_ACC: begin
                    sum_reg <= sum_base + $unsigned(prod_reg);
                    if (last) begin
                        state_reg <= S_DOT_END;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_DOT_MUL;
                    end
                end
                S_DOT_END: begin
                    d_reg     <= MW'(trunc_shr($signed(sum_reg), FRAC_BITS));
                    idx_reg   <= '0;
                    state_reg <= clamp_ph_reg ? S_ALG_MUL : S_GND_MUL;
                end
                // on ground: drop the component along gravity
                S_GND_MUL: state_reg <= S_GND_UPD;
                S_GND_UPD: begin
                    vel_reg[idx_reg] <= sat32(64'(vel_reg[idx_reg])
                                              - trunc_shr(prod_reg, FRAC_BITS));
                    if (last) begin
                        idx_reg      <= '0;
                        clamp_ph_reg <= 1'b1;
                        state_reg    <= S_DOT_MUL;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_GND_MUL;
                    end
                end
                // in air: add gravity times the step
                S_GRV_MUL: state_reg <= S_GRV_UPD;
                S_GRV_UPD: begin
                    vel_reg[idx_reg] <= sat32(64'(vel_reg[idx_reg]) + trunc_shr(prod_reg, 16));
                    if (last) begin
                        idx_reg      <= '0;
                        clamp_ph_reg <= 1'b1;
                        state_reg    <= S_DOT_MUL;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_GRV_MUL;
                    end
                end
                // sideways part from the unclamped dot
                S_ALG_MUL: state_reg <= S_ALG_UPD;
                S_ALG_UPD: begin
                    side_reg[idx_reg] <= side_c;
                    mag_reg[idx_reg]  <= mag_c;
                    if (last) begin
                        if (d_reg > lim_a) begin
                            d_reg <= lim_a;
                        end else if (d_reg < -lim_a) begin
                            d_reg <= -lim_a;
                        end
                        idx_reg   <= '0;
                        state_reg <= S_ALC_MUL;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_ALG_MUL;
                    end
                end
                // along part from the clamped dot
                S_ALC_MUL: state_reg <= S_ALC_UPD;
                S_ALC_UPD: begin
                    along_reg[idx_reg] <= along_c;
                    sh_reg             <= sh_c;
                    if (last) begin
                        idx_reg   <= '0;
                        state_reg <= S_SSQ_MUL;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_ALC_MUL;
                    end
                end
                // sideways length
                S_SSQ_MUL: state_reg <= S_SSQ_ACC;
                S_SSQ_ACC: begin
                    sum_reg <= sum_base + $unsigned(prod_reg);
                    if (last) begin
                        idx_reg   <= '0;
                        state_reg <= S_SLEN;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SSQ_MUL;
                    end
                end
                S_SLEN: begin
                    if (ds_done) begin
                        lenq_reg <= ds_q[31:0];
                        idx_reg  <= '0;
                        if (40'(cfg.limit_side) < (40'(ds_q[31:0]) << sh_reg)) begin
                            state_reg <= S_SCL_MUL;
                        end else begin
                            state_reg <= S_VEL_UPD;
                        end
                    end
                end
                // scale sideways part down to its limit
                S_SCL_MUL: state_reg <= S_SCL_DIV;
                S_SCL_DIV: begin
                    if (ds_done) begin
                        side_reg[idx_reg] <= 36'(apply_sign(side_reg[idx_reg][35], ds_q));
                        if (last) begin
                            idx_reg   <= '0;
                            state_reg <= S_VEL_UPD;
                        end else begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_SCL_MUL;
                        end
                    end
                end
                // recombine velocity
                S_VEL_UPD: begin
                    for (int k = 0; k < 3; k++) begin
                        vel_reg[k] <= sat32(64'(along_reg[k]) + 64'(side_reg[k]));
                    end
                    idx_reg   <= '0;
                    state_reg <= S_POS_MUL;
                end
                // advance position, clear force
                S_POS_MUL: state_reg <= S_POS_UPD;
                S_POS_UPD: begin
                    pos_reg[idx_reg]   <= sat32(64'(pos_reg[idx_reg]) + trunc_shr(prod_reg, 16));
                    force_reg[idx_reg] <= '0;
                    if (last) begin
                        idx_reg   <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_POS_MUL;
                    end
                end
                S_OUT: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_OUT);
    assign res_beat.pos_x = pos_reg[0];
    assign res_beat.pos_y = pos_reg[1];
    assign res_beat.pos_z = pos_reg[2];
    assign res_beat.vel_x = vel_reg[0];
    assign res_beat.vel_y = vel_reg[1];
    assign res_beat.vel_z = vel_reg[2];

endmodule

// ----- tb/rigid_body_velocity_integrator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rigid_body_velocity_integrator_top_tb: self-checking bench for the integrator
// Drives add_force and step beats through a directed table and a random run,
// writes the registers over APB between phases, and checks every result beat
// against a bit-accurate model of the fixed-point integrator.
// ----------------------------------------------------------------------------
module rigid_body_velocity_integrator_top_tb;
    import rbvi_pkg::*;

    localparam int FB = 16;
    localparam int STALL_LIMIT = 20000;

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    in_beat_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_beat_t         m_data;

    rigid_body_velocity_integrator_top #(.FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Body state and register copies
    longint body_mass, grav_v[3], lim_along_v, lim_side_v;
    longint force_acc[3], vel_v[3], pos_v[3];

    out_beat_t expected_beats[$];
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        quiet_cycles;

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint sdiv(longint a, longint b);
        // SV division truncates toward zero
        return a / b;
    endfunction

    function automatic longint by_dt(longint a, longint dt);
        return (a * dt) / 65536;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned absv(longint x);
        return x < 0 ? 64'd0 - longint'(x) : longint'(x);
    endfunction

    function automatic void gravity_unit(output longint u[3]);
        longint unsigned s, len;
        s = 0;
        for (int i = 0; i < 3; i++) s += absv(grav_v[i]) * absv(grav_v[i]);
        len = root64(s);
        for (int i = 0; i < 3; i++)
            u[i] = (len == 0) ? 0 : sdiv(grav_v[i] * (64'sd1 << FB), longint'(len));
    endfunction

    function automatic longint vel_dot(longint u[3]);
        return (vel_v[0] * u[0] + vel_v[1] * u[1] + vel_v[2] * u[2]) / (64'sd1 << FB);
    endfunction

    // Clamp the along-gravity and sideways parts and recombine them
    function automatic void limit_velocity(longint u[3]);
        longint d, along[3], side[3], m;
        longint unsigned mg[3], mx, s, lenq;
        int sh;
        d = vel_dot(u);
        mx = 0;
        s = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            along[i] = u[i] * d / (64'sd1 << FB);
            side[i] = vel_v[i] - along[i];
            mg[i] = absv(side[i]);
            if (mg[i] > mx) mx = mg[i];
        end
        if (d > lim_along_v) d = lim_along_v;
        if (d < -lim_along_v) d = -lim_along_v;
        for (int i = 0; i < 3; i++) along[i] = u[i] * d / (64'sd1 << FB);
        while ((mx >> sh) >= (64'd1 << 31)) sh++;
        for (int i = 0; i < 3; i++) s += (mg[i] >> sh) * (mg[i] >> sh);
        lenq = root64(s);
        if (longint'(lim_side_v) < (lenq << sh)) begin
            for (int i = 0; i < 3; i++) begin
                m = longint'(((mg[i] >> sh) * longint'(lim_side_v)) / lenq);
                side[i] = side[i] < 0 ? -m : m;
            end
        end
        for (int i = 0; i < 3; i++) vel_v[i] = clip32(along[i] + side[i]);
    endfunction

    // Advance the body by one beat and return the state it reports
    function automatic out_beat_t integrate_beat(in_beat_t b);
        longint u[3], d, m, acc, vin[3], dt;
        out_beat_t r;
        vin[0] = b.vec_x;
        vin[1] = b.vec_y;
        vin[2] = b.vec_z;
        dt = b.time_step;
        if (b.action == ACT_ADD_FORCE) begin
            for (int i = 0; i < 3; i++) force_acc[i] = clip32(force_acc[i] + vin[i]);
        end else begin
            m = (body_mass == 0) ? 1 : body_mass;
            for (int i = 0; i < 3; i++) begin
                acc = clip32(sdiv(force_acc[i] * (64'sd1 << FB), m));
                vel_v[i] = clip32(vel_v[i] + by_dt(acc, dt));
            end
            gravity_unit(u);
            if (b.on_ground) begin
                d = vel_dot(u);
                for (int i = 0; i < 3; i++)
                    vel_v[i] = clip32(vel_v[i] - u[i] * d / (64'sd1 << FB));
            end else begin
                for (int i = 0; i < 3; i++) vel_v[i] = clip32(vel_v[i] + by_dt(grav_v[i], dt));
            end
            limit_velocity(u);
            for (int i = 0; i < 3; i++) begin
                pos_v[i] = clip32(pos_v[i] + by_dt(vel_v[i], dt));
                force_acc[i] = 0;
            end
        end
        r.pos_x = pos_v[0][31:0];
        r.pos_y = pos_v[1][31:0];
        r.pos_z = pos_v[2][31:0];
        r.vel_x = vel_v[0][31:0];
        r.vel_y = vel_v[1][31:0];
        r.vel_z = vel_v[2][31:0];
        return r;
    endfunction

    // APB write: setup then access, register taken at the access edge
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MASS:        body_mass = longint'(val);
            REG_GRAVITY_X:   grav_v[0] = longint'($signed(val));
            REG_GRAVITY_Y:   grav_v[1] = longint'($signed(val));
            REG_GRAVITY_Z:   grav_v[2] = longint'($signed(val));
            REG_LIMIT_ALONG: lim_along_v = longint'(val[30:0]);
            REG_LIMIT_SIDE:  lim_side_v = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    // Send one beat, with random idle ahead of it; valid drops only while idling
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_beats.push_back(integrate_beat(b));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (800) @(negedge aclk);
    endtask

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        b.action = ($urandom_range(99) < 55) ? ACT_ADD_FORCE : ACT_STEP;
        b.vec_x = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(400000)) - 200000;
        b.vec_y = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(400000)) - 200000;
        b.vec_z = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(400000)) - 200000;
        b.time_step = 16'($urandom_range(3) == 0 ? $urandom_range(65535)
                                                 : $urandom_range(2000));
        b.on_ground = 1'($urandom_range(1));
        return b;
    endfunction

    // Output side: random stall, compare each beat with the oldest expectation
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                errors++;
            end else begin
                if (m_data !== expected_beats[0]) begin
                    $display("%0t: mismatch expected pos %0d %0d %0d vel %0d %0d %0d",
                             $time, expected_beats[0].pos_x, expected_beats[0].pos_y,
                             expected_beats[0].pos_z, expected_beats[0].vel_x,
                             expected_beats[0].vel_y, expected_beats[0].vel_z);
                    $display("%0t:          actual   pos %0d %0d %0d vel %0d %0d %0d",
                             $time, m_data.pos_x, m_data.pos_y, m_data.pos_z,
                             m_data.vel_x, m_data.vel_y, m_data.vel_z);
                    errors++;
                end
                void'(expected_beats.pop_front());
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn ||
            (s_valid == 1'b0 && expected_beats.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    typedef struct {
        in_beat_t  beat;
        logic      typed;
        out_beat_t result;
    } stim_row_t;

    stim_row_t directed_rows[$];

    function automatic in_beat_t mk(logic act, int x, int y, int z, int dt, logic g);
        in_beat_t b;
        b.action = act;
        b.vec_x = x;
        b.vec_y = y;
        b.vec_z = z;
        b.time_step = 16'(dt);
        b.on_ground = g;
        return b;
    endfunction

    initial begin
        stim_row_t row;
        in_beat_t  b;
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_data = '0; m_ready = 1'b1;
        body_mass = 65536; grav_v[0] = 0; grav_v[1] = 6553600; grav_v[2] = 0;
        lim_along_v = 65536000; lim_side_v = 13107200;
        for (int i = 0; i < 3; i++) begin
            force_acc[i] = 0; vel_v[i] = 0; pos_v[i] = 0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: rows with typed results are obvious from reset state
        row.typed = 1; row.result = '0;
        row.beat = mk(ACT_ADD_FORCE, 0, 0, 0, 0, 0); directed_rows.push_back(row);
        row.beat = mk(ACT_STEP, 0, 0, 0, 0, 1); directed_rows.push_back(row);
        row.typed = 0;
        row.beat = mk(ACT_ADD_FORCE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 65535, 1);
        directed_rows.push_back(row);
        row.beat = mk(ACT_ADD_FORCE, 32'h7FFFFFFF, 32'h80000000, 1, 0, 0);
        directed_rows.push_back(row);
        row.beat = mk(ACT_STEP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 65535, 0);
        directed_rows.push_back(row);
        row.beat = mk(ACT_STEP, 0, 0, 0, 65535, 1); directed_rows.push_back(row);
        row.beat = mk(ACT_STEP, 0, 0, 0, 65535, 0); directed_rows.push_back(row);
        row.beat = mk(ACT_ADD_FORCE, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0);
        directed_rows.push_back(row);
        row.beat = mk(ACT_STEP, 0, 0, 0, 1, 0); directed_rows.push_back(row);
        row.beat = mk(ACT_STEP, 0, 0, 0, 32768, 1); directed_rows.push_back(row);

        foreach (directed_rows[k]) begin
            send_beat(directed_rows[k].beat);
            if (directed_rows[k].typed &&
                expected_beats[$] !== directed_rows[k].result) begin
                $display("%0t: table row %0d expected %h got prediction %h",
                         $time, k, directed_rows[k].result, expected_beats[$]);
                errors++;
            end
        end
        drain();

        // Zero mass, zero gravity, zero limits
        reg_write(REG_MASS, 32'd0);
        reg_write(REG_GRAVITY_X, 32'd0);
        reg_write(REG_GRAVITY_Y, 32'd0);
        reg_write(REG_GRAVITY_Z, 32'd0);
        reg_write(REG_LIMIT_ALONG, 32'd0);
        reg_write(REG_LIMIT_SIDE, 32'd0);
        send_beat(mk(ACT_ADD_FORCE, 1000, -1000, 5, 0, 0));
        send_beat(mk(ACT_STEP, 0, 0, 0, 65535, 0));
        send_beat(mk(ACT_STEP, 0, 0, 0, 65535, 1));
        drain();

        // Extreme gravity and limits, big mass
        reg_write(REG_MASS, 32'hFFFFFFFF);
        reg_write(REG_GRAVITY_X, 32'h80000000);
        reg_write(REG_GRAVITY_Y, 32'h7FFFFFFF);
        reg_write(REG_GRAVITY_Z, 32'h80000000);
        reg_write(REG_LIMIT_ALONG, 32'hFFFFFFFF);
        reg_write(REG_LIMIT_SIDE, 32'h7FFFFFFF);
        send_beat(mk(ACT_ADD_FORCE, 32'h7FFFFFFF, 0, 32'h80000000, 0, 0));
        send_beat(mk(ACT_STEP, 0, 0, 0, 65535, 0));
        send_beat(mk(ACT_STEP, 0, 0, 0, 65535, 1));
        send_beat(mk(ACT_STEP, 0, 0, 0, 65535, 0));
        drain();

        // Random phases, new settings at each
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            reg_write(REG_MASS, $urandom_range(3) == 0 ? $urandom() : $urandom_range(1 << 20));
            reg_write(REG_GRAVITY_X, $signed($urandom_range(2000000)) - 1000000);
            reg_write(REG_GRAVITY_Y, $urandom_range(4) == 0 ? $urandom()
                                     : $signed($urandom_range(20000000)) - 10000000);
            reg_write(REG_GRAVITY_Z, $urandom_range(5) == 0 ? 0
                                     : $signed($urandom_range(2000000)) - 1000000);
            reg_write(REG_LIMIT_ALONG, $urandom_range(3) == 0 ? $urandom()
                                       : $urandom_range(80000000));
            reg_write(REG_LIMIT_SIDE, $urandom_range(3) == 0 ? $urandom()
                                      : $urandom_range(20000000));
            for (int n = 0; n < 200; n++) begin
                b = rand_beat();
                send_beat(b);
                // Hold the sender once until all results are back
                if (ph == 0 && n == 100) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                    while (expected_beats.size() != 0) @(negedge aclk);
                end
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        if (errors == 0 && expected_beats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
